/* design/dtpd_pkg.sv */
// ----------------------------------------------------------------------------
// dtpd_pkg
// Shared types, constants and helpers of the disk track protection detector.
// ----------------------------------------------------------------------------
package dtpd_pkg;

  // Track length limit; every counter saturates here
  localparam int unsigned MAX_TRACK_BYTES = 8192;
  localparam int unsigned CNT_W  = $clog2(MAX_TRACK_BYTES + 1);
  // Room for 10 * count in the ratio checks
  localparam int unsigned PROD_W = CNT_W + 4;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [PROD_W-1:0] prod_t;

  localparam cnt_t CNT_MAX = cnt_t'(MAX_TRACK_BYTES);

  // Byte classes
  localparam logic [7:0] NIBBLE_MIN = 8'h96;
  localparam logic [7:0] SYNC_VALUE = 8'hFF;

  // Configuration registers
  localparam int unsigned CFG_DATA_W = 14;
  localparam logic REG_MAX_REPORTS     = 1'b0;
  localparam logic REG_LONG_SYNC_LIMIT = 1'b1;
  localparam logic [1:0]  MAX_REPORTS_RESET     = 2'd3;
  localparam logic [13:0] LONG_SYNC_LIMIT_RESET = 14'd40;

  // Report kinds and their confidence
  localparam logic [1:0] KIND_LONG_SYNC = 2'd0;
  localparam logic [1:0] KIND_WEAK_BITS = 2'd1;
  localparam logic [1:0] KIND_CUSTOM    = 2'd2;
  localparam logic [6:0] PCT_LONG_SYNC  = 7'd85;
  localparam logic [6:0] PCT_WEAK_BITS  = 7'd70;
  localparam logic [6:0] PCT_CUSTOM     = 7'd65;

  // Queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] bits_in_byte;
    logic       last_byte;
  } track_byte_t;

  typedef struct packed {
    logic [1:0] protection_kind;
    logic [6:0] confidence_pct;
    logic       last_report;
  } report_t;

  // One bit per report kind, already limited to max_reports
  typedef struct packed {
    logic custom;
    logic weak_bits;
    logic long_sync;
  } report_mask_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic almost_full;
  } q_status_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v < CNT_MAX) ? v + cnt_t'(1) : CNT_MAX;
  endfunction

endpackage

/* design/dtpd_front.sv */
// ----------------------------------------------------------------------------
// dtpd_front
// Counts bytes of a track, snapshots the totals on the last byte and
// classifies the track into a mask of protection reports.
// ----------------------------------------------------------------------------
module dtpd_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  dtpd_pkg::track_byte_t track_byte,
  input  logic [1:0]            max_reports,
  input  logic [13:0]           long_sync_limit,
  input  dtpd_pkg::q_status_t   q_status,
  output logic                  q_push,
  output dtpd_pkg::report_mask_t q_mask
);
  import dtpd_pkg::*;

  logic accept;
  logic is_full_byte, is_valid, is_sync;

  cnt_t byte_total, valid_total, sync_total, sync_run, longest_run;
  cnt_t byte_total_next, valid_total_next, sync_total_next;
  cnt_t sync_run_next, longest_run_next;

  logic snap_valid;
  cnt_t snap_bytes, snap_valid_cnt, snap_sync, snap_longest;

  prod_t t_x2, t_x3, t_x9, v_x10, s_x5;
  logic  hit_long, hit_weak, hit_custom;
  logic  take_long, take_weak, take_custom;
  logic [1:0] taken_before_custom;

  // Leave room for a snapshot still on its way into the queue
  assign full   = snap_valid ? q_status.almost_full : q_status.full;
  assign accept = push && !full;

  assign is_full_byte = track_byte.bits_in_byte[3];
  assign is_valid     = track_byte.data_byte >= NIBBLE_MIN;
  assign is_sync      = track_byte.data_byte == SYNC_VALUE;

  // Advance the counters for one byte
  always_comb begin
    byte_total_next  = byte_total;
    valid_total_next = valid_total;
    sync_total_next  = sync_total;
    sync_run_next    = sync_run;
    longest_run_next = longest_run;
    if (is_full_byte) begin
      byte_total_next = sat_inc(byte_total);
      if (is_valid) begin
        valid_total_next = sat_inc(valid_total);
        if (is_sync) begin
          sync_total_next = sat_inc(sync_total);
          sync_run_next   = sat_inc(sync_run);
          if (sync_run_next > longest_run) begin
            longest_run_next = sync_run_next;
          end
        end else begin
          sync_run_next = '0;
        end
      end
    end
  end

  // Hold counters; clear them and take a snapshot at the end of a track
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_total  <= '0;
      valid_total <= '0;
      sync_total  <= '0;
      sync_run    <= '0;
      longest_run <= '0;
      snap_valid  <= 1'b0;
    end else begin
      snap_valid <= accept && track_byte.last_byte;
      if (accept) begin
        if (track_byte.last_byte) begin
          byte_total  <= '0;
          valid_total <= '0;
          sync_total  <= '0;
          sync_run    <= '0;
          longest_run <= '0;
        end else begin
          byte_total  <= byte_total_next;
          valid_total <= valid_total_next;
          sync_total  <= sync_total_next;
          sync_run    <= sync_run_next;
          longest_run <= longest_run_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && track_byte.last_byte) begin
      snap_bytes     <= byte_total_next;
      snap_valid_cnt <= valid_total_next;
      snap_sync      <= sync_total_next;
      snap_longest   <= longest_run_next;
    end
  end

  // Ratio checks as constant cross-multiplications
  always_comb begin
    t_x2  = prod_t'(snap_bytes) << 1;
    t_x3  = (prod_t'(snap_bytes) << 1) + prod_t'(snap_bytes);
    t_x9  = (prod_t'(snap_bytes) << 3) + prod_t'(snap_bytes);
    v_x10 = (prod_t'(snap_valid_cnt) << 3) + (prod_t'(snap_valid_cnt) << 1);
    s_x5  = (prod_t'(snap_sync) << 2) + prod_t'(snap_sync);

    hit_long   = snap_longest > long_sync_limit;
    hit_weak   = (snap_bytes == '0) || (v_x10 < t_x9);
    hit_custom = (s_x5 > t_x2) && (s_x5 < t_x3);

    // Keep only the first max_reports hits, in report order
    take_long   = hit_long && (max_reports != 2'd0);
    take_weak   = hit_weak && ({1'b0, take_long} < max_reports);
    taken_before_custom = {1'b0, take_long} + {1'b0, take_weak};
    take_custom = hit_custom && (taken_before_custom < max_reports);

    q_mask.long_sync = take_long;
    q_mask.weak_bits = take_weak;
    q_mask.custom    = take_custom;
    q_push = snap_valid && (take_long || take_weak || take_custom);
  end

endmodule

/* design/dtpd_fifo.sv */
// ----------------------------------------------------------------------------
// dtpd_fifo
// Short queue of report masks between the classifier and the report sequencer.
// ----------------------------------------------------------------------------
module dtpd_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  dtpd_pkg::report_mask_t wr_data,
  output dtpd_pkg::q_status_t    status,
  input  logic                   rd_en,
  output logic                   rd_empty,
  output dtpd_pkg::report_mask_t rd_data
);
  import dtpd_pkg::*;

  report_mask_t       mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QPTR_W:0]    count;
  logic               do_wr, do_rd;

  assign do_wr = wr_en && !status.full;
  assign do_rd = rd_en && !rd_empty;

  assign status.full        = count == (QPTR_W + 1)'(QDEPTH);
  assign status.almost_full = count >= (QPTR_W + 1)'(QDEPTH - 1);
  assign rd_empty           = count == '0;
  assign rd_data            = mem[rd_ptr];

  // Store incoming masks
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/dtpd_back.sv */
// ----------------------------------------------------------------------------
// dtpd_back
// Expands each report mask into report requests, one per cycle while the
// output register is empty or being popped, through that output register.
// ----------------------------------------------------------------------------
module dtpd_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  dtpd_pkg::report_mask_t q_mask,
  output logic                   q_pop,
  output logic                   empty,
  input  logic                   pop,
  output dtpd_pkg::report_t      report
);
  import dtpd_pkg::*;

  report_mask_t cur, cur_next, work;
  logic         out_valid, out_valid_next;
  report_t      out_next;
  logic         can_emit;

  assign empty    = !out_valid;
  assign can_emit = !out_valid || pop;

  // Pick the next kind in report order and retire it
  always_comb begin
    work           = cur;
    q_pop          = 1'b0;
    out_valid_next = out_valid && !pop;
    out_next       = report;
    if ((work == '0) && !q_empty) begin
      work  = q_mask;
      q_pop = 1'b1;
    end
    if (can_emit && (work != '0)) begin
      out_valid_next = 1'b1;
      priority if (work.long_sync) begin
        out_next.protection_kind = KIND_LONG_SYNC;
        out_next.confidence_pct  = PCT_LONG_SYNC;
        work.long_sync = 1'b0;
      end else if (work.weak_bits) begin
        out_next.protection_kind = KIND_WEAK_BITS;
        out_next.confidence_pct  = PCT_WEAK_BITS;
        work.weak_bits = 1'b0;
      end else begin
        out_next.protection_kind = KIND_CUSTOM;
        out_next.confidence_pct  = PCT_CUSTOM;
        work.custom = 1'b0;
      end
      out_next.last_report = work == '0;
    end
    cur_next = work;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= '0;
      out_valid <= 1'b0;
    end else begin
      cur       <= cur_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    report <= out_next;
  end

endmodule

/* design/disk_track_protection_detector_top.sv */
// ----------------------------------------------------------------------------
// disk_track_protection_detector_top
// Track statistics and copy protection reports for a byte stream.
// ----------------------------------------------------------------------------
// Takes one track byte per cycle while full is low; full rises only while the
// report queue (four report masks deep) is backed up. The last byte of a track
// is captured in the snapshot registers, its report mask is then written into
// the report queue, and the sequencer moves its first report into the output
// register. The reports of a track leave one per cycle through it while pop
// is held; a track yields up to three reports, no faster than one per cycle.
// Write configuration only while no track is in flight.
module disk_track_protection_detector_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  dtpd_pkg::track_byte_t               track_byte,
  output logic                                empty,
  input  logic                                pop,
  output dtpd_pkg::report_t                   report,
  input  logic                                write_en,
  input  logic                                reg_index,
  input  logic [dtpd_pkg::CFG_DATA_W-1:0]     write_data
);
  import dtpd_pkg::*;

  logic [1:0]   max_reports;
  logic [13:0]  long_sync_limit;
  q_status_t    q_status;
  logic         q_push, q_pop, q_empty;
  report_mask_t q_wr_mask, q_rd_mask;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_reports     <= MAX_REPORTS_RESET;
      long_sync_limit <= LONG_SYNC_LIMIT_RESET;
    end else if (write_en) begin
      unique case (reg_index)
        REG_MAX_REPORTS:     max_reports     <= write_data[1:0];
        REG_LONG_SYNC_LIMIT: long_sync_limit <= write_data[13:0];
        default: ;
      endcase
    end
  end

  dtpd_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .track_byte      (track_byte),
    .max_reports     (max_reports),
    .long_sync_limit (long_sync_limit),
    .q_status        (q_status),
    .q_push          (q_push),
    .q_mask          (q_wr_mask)
  );

  dtpd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_data  (q_wr_mask),
    .status   (q_status),
    .rd_en    (q_pop),
    .rd_empty (q_empty),
    .rd_data  (q_rd_mask)
  );

  dtpd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_mask  (q_rd_mask),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .report  (report)
  );

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the disk track protection detector.
// ----------------------------------------------------------------------------
// Feeds tracks of bytes through the push/full side and checks every report
// popped from the result side against a cycle-free model of the track
// statistics that runs at the point each byte is taken. Covers directed
// corner tracks, every report limit, a long output stall that backs up the
// input, and random tracks under random idling.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dtpd_pkg::*;

  localparam int          CLK_HALF       = 4;
  localparam int          RESET_CYCLES   = 12;
  localparam int          SETTLE_CYCLES  = 12;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam logic [3:0]  FULL_BYTE_BITS = 4'd8;
  localparam logic [13:0] SYNC_LIMIT_TOP = 14'd8192;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  track_byte_t track_byte = '0;
  logic        empty;
  logic        pop = 1'b0;
  report_t     report;
  logic        write_en = 1'b0;
  logic        reg_index = REG_MAX_REPORTS;
  logic [CFG_DATA_W-1:0] write_data = '0;

  disk_track_protection_detector_top dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .track_byte (track_byte),
    .empty      (empty),
    .pop        (pop),
    .report     (report),
    .write_en   (write_en),
    .reg_index  (reg_index),
    .write_data (write_data)
  );

  // Byte requests waiting to be sent, and reports the model says must come
  track_byte_t byte_pending_q[$];
  report_t     report_due_q[$];

  // Model copy of the configuration and the per-track counters
  logic [1:0]  cfg_max_reports = MAX_REPORTS_RESET;
  logic [13:0] cfg_sync_limit  = LONG_SYNC_LIMIT_RESET;
  cnt_t        n_bytes = '0;
  cnt_t        n_valid = '0;
  cnt_t        n_sync  = '0;
  cnt_t        run_len = '0;
  cnt_t        best_run = '0;

  int errors        = 0;
  int tracks_sent   = 0;
  int bytes_sent    = 0;
  int reports_seen  = 0;
  int stall_cycles  = 0;
  int send_gap      = 0;
  int recv_gap      = 0;
  int hold_left     = 0;
  int holds_asked   = 0;
  int holds_done    = 0;
  int quiet_cycles  = 0;
  bit calm          = 1'b0;

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  function automatic cnt_t count_up(input cnt_t v);
    return (v < CNT_MAX) ? v + 1'b1 : CNT_MAX;
  endfunction

  // Advance the track counters by one byte; on the last byte queue reports
  task automatic track_stats_step(input track_byte_t tb);
    report_t found [3];
    int      n;
    report_t r;
    n = 0;
    if (tb.bits_in_byte >= FULL_BYTE_BITS) begin
      n_bytes = count_up(n_bytes);
      if (tb.data_byte >= NIBBLE_MIN) begin
        n_valid = count_up(n_valid);
        if (tb.data_byte == SYNC_VALUE) begin
          n_sync  = count_up(n_sync);
          run_len = count_up(run_len);
          if (run_len > best_run) best_run = run_len;
        end else begin
          run_len = '0;
        end
      end
    end
    if (tb.last_byte) begin
      if (best_run > cfg_sync_limit && n < cfg_max_reports) begin
        found[n] = {KIND_LONG_SYNC, PCT_LONG_SYNC, 1'b0};
        n++;
      end
      if ((n_bytes == 0 || n_valid * 10 < n_bytes * 9) && n < cfg_max_reports) begin
        found[n] = {KIND_WEAK_BITS, PCT_WEAK_BITS, 1'b0};
        n++;
      end
      if (n_sync * 5 > n_bytes * 2 && n_sync * 5 < n_bytes * 3 && n < cfg_max_reports) begin
        found[n] = {KIND_CUSTOM, PCT_CUSTOM, 1'b0};
        n++;
      end
      for (int i = 0; i < n; i++) begin
        r = found[i];
        r.last_report = (i == n - 1);
        report_due_q.push_back(r);
      end
      n_bytes  = '0;
      n_valid  = '0;
      n_sync   = '0;
      run_len  = '0;
      best_run = '0;
    end
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, want %0d (report %0d)", what, got, want, reports_seen);
    errors++;
  endtask

  // Sender: offer the oldest pending request, with random gaps
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        track_stats_step(track_byte);
        void'(byte_pending_q.pop_front());
        bytes_sent++;
        if (track_byte.last_byte) tracks_sent++;
      end
      if (push && full) stall_cycles++;
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (byte_pending_q.size() != 0 && !calm && $urandom_range(0, 15) == 0) begin
        send_gap = $urandom_range(1, 11) - 1;
        push <= 1'b0;
      end else if (byte_pending_q.size() != 0) begin
        push       <= 1'b1;
        track_byte <= byte_pending_q[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: check each popped report, with random gaps and long holds
  always @(posedge clk) begin
    report_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (report_due_q.size() == 0) begin
          flag_mismatch("report with none due, kind", report.protection_kind, -1);
        end else begin
          want = report_due_q.pop_front();
          if (report.protection_kind !== want.protection_kind)
            flag_mismatch("protection_kind", report.protection_kind, want.protection_kind);
          if (report.confidence_pct !== want.confidence_pct)
            flag_mismatch("confidence_pct", report.confidence_pct, want.confidence_pct);
          if (report.last_report !== want.last_report)
            flag_mismatch("last_report", report.last_report, want.last_report);
        end
        reports_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (holds_asked != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES - 1;
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        recv_gap = $urandom_range(1, 11) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || write_en || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] data, input logic [3:0] bits, input logic last);
    byte_pending_q.push_back({data, bits, last});
  endtask

  task automatic write_reg(input logic idx, input logic [13:0] val);
    @(posedge clk);
    write_en   <= 1'b1;
    reg_index  <= idx;
    write_data <= val;
    if (idx == REG_MAX_REPORTS) cfg_max_reports = val[1:0];
    else cfg_sync_limit = val;
    @(posedge clk);
    write_en <= 1'b0;
  endtask

  // Hold until every request is taken and every report is back, then settle
  task automatic wait_drained();
    @(negedge clk);
    while (byte_pending_q.size() != 0 || report_due_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One well-formed track with random mix; some carry odd bit counts
  task automatic add_random_track();
    int         len;
    int         sync_pct;
    int         valid_pct;
    bit         noisy;
    logic [7:0] data;
    logic [3:0] bits;
    len       = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
    sync_pct  = $urandom_range(0, 100);
    valid_pct = $urandom_range(0, 100);
    noisy     = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < sync_pct) data = SYNC_VALUE;
      else if ($urandom_range(0, 99) < valid_pct) data = 8'($urandom_range(8'h96, 8'hFE));
      else data = 8'($urandom_range(0, 8'h95));
      if (i == len - 1)
        bits = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 7))
                                           : 4'($urandom_range(8, 15));
      else if (noisy)
        bits = 4'($urandom_range(0, 15));
      else
        bits = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : FULL_BYTE_BITS;
      add_byte(data, bits, i == len - 1);
    end
  endtask

  task automatic random_phase(input int items);
    int target;
    target = byte_pending_q.size() + items;
    while (byte_pending_q.size() < target) add_random_track();
  endtask

  // Stimulus sequence: directed corners, pressure, random
  initial begin
    logic [1:0]  pick_max;
    logic [13:0] pick_limit;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: empty track, single sync byte, mixed bit counts
    @(negedge clk);
    add_byte(8'h00, 4'd0, 1'b1);
    add_byte(SYNC_VALUE, FULL_BYTE_BITS, 1'b1);
    add_byte(NIBBLE_MIN, FULL_BYTE_BITS, 1'b0);
    add_byte(8'h95, 4'd15, 1'b1);
    add_byte(8'h00, 4'd4, 1'b0);
    add_byte(SYNC_VALUE, FULL_BYTE_BITS, 1'b0);
    add_byte(8'hFE, FULL_BYTE_BITS, 1'b0);
    add_byte(8'h00, FULL_BYTE_BITS, 1'b1);
    wait_drained();

    // Zero limit: runs broken by valid bytes only, partial last byte
    write_reg(REG_LONG_SYNC_LIMIT, 14'd0);
    @(negedge clk);
    add_byte(SYNC_VALUE, FULL_BYTE_BITS, 1'b0);
    add_byte(SYNC_VALUE, 4'd9, 1'b0);
    add_byte(8'h12, FULL_BYTE_BITS, 1'b0);
    add_byte(SYNC_VALUE, FULL_BYTE_BITS, 1'b0);
    add_byte(8'hA0, FULL_BYTE_BITS, 1'b0);
    add_byte(SYNC_VALUE, FULL_BYTE_BITS, 1'b0);
    add_byte(8'h7F, 4'd4, 1'b1);
    add_byte(8'h00, FULL_BYTE_BITS, 1'b0);
    add_byte(SYNC_VALUE, FULL_BYTE_BITS, 1'b1);
    wait_drained();

    // Step the report cap down to zero on a track that fires all three
    for (int cap = 2; cap >= 0; cap--) begin
      write_reg(REG_MAX_REPORTS, cap[13:0]);
      if (cap == 0) write_reg(REG_LONG_SYNC_LIMIT, SYNC_LIMIT_TOP);
      @(negedge clk);
      add_byte(8'h00, FULL_BYTE_BITS, 1'b0);
      add_byte(SYNC_VALUE, FULL_BYTE_BITS, 1'b1);
      wait_drained();
    end

    // Back up the result side while the sender keeps offering tracks
    write_reg(REG_MAX_REPORTS, 14'd3);
    @(negedge clk);
    holds_asked++;
    for (int i = 0; i < 16; i++) add_byte(8'h00, FULL_BYTE_BITS, 1'b1);
    wait_drained();

    // Random tracks under varied settings; the last phase runs without gaps
    for (int ph = 0; ph < 5; ph++) begin
      pick_max   = (ph == 0 || ph == 4) ? 2'd3 : 2'($urandom_range(0, 3));
      pick_limit = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 8192))
                                               : 14'($urandom_range(0, 12));
      write_reg(REG_MAX_REPORTS, {12'd0, pick_max});
      write_reg(REG_LONG_SYNC_LIMIT, pick_limit);
      @(negedge clk);
      if (ph == 4) calm = 1'b1;
      random_phase(50);
      wait_drained();
    end

    if (report_due_q.size() != 0)
      flag_mismatch("reports never arrived", 0, report_due_q.size());
    $display("covered %0d tracks, %0d bytes, %0d reports checked", tracks_sent, bytes_sent,
             reports_seen);
    $display("input held off by full for %0d cycles", stall_cycles);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
